/* rtl/core/nmvb_pkg.sv */
// Shared constants, types and the symbol mapping for the match vector builder.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package nmvb_pkg;

  localparam int LANES       = 8;
  localparam int SYMBOLS     = 5;
  localparam int WORD_BITS   = 64;
  localparam int MATCH_W     = 64;
  localparam int CHAR_W      = 8;
  localparam int IN_LANES    = 8;
  localparam int IN_W        = IN_LANES * CHAR_W;
  localparam int DRAIN_N     = SYMBOLS * LANES;
  localparam int DRAIN_CNT_W = $clog2(DRAIN_N + 1);
  localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SYM_W       = 3;
  localparam int POS_W       = 7;
  localparam int WNUM_W      = 7;
  localparam int LEN_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_FIELD_W = SYM_W + 3 + WNUM_W + MATCH_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic [MATCH_W-1:0] word_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_WORD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LENGTH = 1'd1;

  localparam logic [LEN_W-1:0] READ_LENGTH_RESET = 13'd100;

  localparam char_t CHAR_C = 8'h43;
  localparam char_t CHAR_G = 8'h47;
  localparam char_t CHAR_T = 8'h54;
  localparam char_t CHAR_N = 8'h4E;

  localparam sym_t SYM_A = 3'd0;
  localparam sym_t SYM_C = 3'd1;
  localparam sym_t SYM_G = 3'd2;
  localparam sym_t SYM_T = 3'd3;
  localparam sym_t SYM_N = 3'd4;

  // Load request from the control logic into the drain stage
  typedef struct packed {
    logic              load;
    logic [WNUM_W-1:0] word_index;
  } drain_load_t;

  // Drain stage occupancy, seen by the control logic
  typedef struct packed {
    logic empty;
    logic final_beat;
  } drain_status_t;

  // Anything that is not C, G, T or N counts as A
  function automatic sym_t map_symbol(input char_t ch);
    sym_t s;
    unique case (ch)
      CHAR_C:  s = SYM_C;
      CHAR_G:  s = SYM_G;
      CHAR_T:  s = SYM_T;
      CHAR_N:  s = SYM_N;
      default: s = SYM_A;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/nmvb_lane.sv */
// One lane: the five symbol words of a read being built.
// Depends on nmvb_pkg.
`timescale 1ns / 1ps

module nmvb_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  nmvb_pkg::char_t                ch,
  input  nmvb_pkg::word_t                bit_mask,
  input  logic                           advance,
  input  logic                           flush,
  output nmvb_pkg::word_t [nmvb_pkg::SYMBOLS-1:0] set_words
);
  import nmvb_pkg::*;

  word_t [SYMBOLS-1:0] words;
  sym_t                sym;

  assign sym = map_symbol(ch);

  // Words with the current position already marked
  always_comb begin
    for (int s = 0; s < SYMBOLS; s++) begin
      set_words[s] = words[s] | ((sym == SYM_W'(s)) ? bit_mask : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
    end else if (advance) begin
      words <= flush ? '0 : set_words;
    end
  end

endmodule

/* rtl/core/nmvb_drain.sv */
// Merge stage: holds a finished burst of words from all lanes and sends
// them one beat at a time, symbol by symbol and lane by lane. Depends on nmvb_pkg.
`timescale 1ns / 1ps

module nmvb_drain (
  input  logic                                    clk,
  input  logic                                    rst,
  input  nmvb_pkg::drain_load_t                   ld,
  input  nmvb_pkg::word_t [nmvb_pkg::DRAIN_N-1:0] load_words,
  output nmvb_pkg::drain_status_t                 status,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // tdata: symbol_code[2:0], lane_number[5:3], word_number[12:6],
  //        match_bits[76:13], zero fill above
  output logic [nmvb_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tlast
);
  import nmvb_pkg::*;

  word_t [DRAIN_N-1:0] regs;
  logic [DRAIN_CNT_W-1:0] count;
  logic [SYM_W-1:0]       sym_cnt;
  logic [LANE_W-1:0]      lane_cnt;
  logic [WNUM_W-1:0]      burst_word;
  logic                   beat;

  assign beat              = m_tvalid && m_tready;
  assign m_tvalid          = (count != '0);
  assign m_tlast           = (count == DRAIN_CNT_W'(1));
  assign status.empty      = (count == '0);
  assign status.final_beat = (count == DRAIN_CNT_W'(1));

  assign m_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), regs[0], burst_word,
                    3'(lane_cnt), sym_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sym_cnt  <= '0;
      lane_cnt <= '0;
    end else if (ld.load) begin
      count    <= DRAIN_CNT_W'(DRAIN_N);
      sym_cnt  <= '0;
      lane_cnt <= '0;
    end else if (beat) begin
      count <= count - DRAIN_CNT_W'(1);
      if (lane_cnt == LANE_W'(LANES - 1)) begin
        lane_cnt <= '0;
        sym_cnt  <= sym_cnt + SYM_W'(1);
      end else begin
        lane_cnt <= lane_cnt + LANE_W'(1);
      end
    end
  end

  // Payload: load the whole burst, then shift one word down per beat
  always_ff @(posedge clk) begin
    if (ld.load) begin
      regs       <= load_words;
      burst_word <= ld.word_index;
    end else if (beat) begin
      for (int k = 0; k < DRAIN_N - 1; k++) begin
        regs[k] <= regs[k + 1];
      end
    end
  end

endmodule

/* rtl/core/nucleotide_match_vector_builder.sv */
// Top level of the nucleotide match vector builder: position control, the
// lane array and the drain stage. Depends on nmvb_pkg, nmvb_lane, nmvb_drain.
`timescale 1ns / 1ps

// Usage
//   s_* channel: one beat per character position, one ASCII byte per lane in
//   s_tdata (lane 0 in the low byte). Every lane maps its byte to A, C, G, T
//   or N (unknown bytes count as A) and marks the current bit of that word.
//   m_* channel: when a word fills (63 or 64 positions, set by full_word) or
//   a read ends (read_length positions), a burst of SYMBOLS*LANES beats leaves,
//   symbol by symbol, lane by lane; tlast marks the final beat of a burst.
//   cfg_*: write full_word (index 0) or read_length (index 1) while idle.
// Timing
//   An input beat is taken every cycle while s_tready is high. The beat that
//   completes a word is copied into the drain stage in the same cycle, so its
//   burst starts in the next cycle and runs one beat per cycle while m_tready
//   is high: 40 beats with the default eight lanes. Inputs keep flowing into
//   fresh words during the burst; only a beat that would complete the next word
//   waits for the final beat; the drain length bounds the rate for short words.
// Reset and stalls
//   rst (synchronous) clears the lane words and all counters and restores
//   full_word = 0, read_length = 100. When the receiver drops m_tready the
//   current beat holds; inputs are still taken until another burst is due.

module nucleotide_match_vector_builder (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [nmvb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nmvb_pkg::LEN_W-1:0]            cfg_data,
  // Input stream; tdata: lane_chars[63:0]
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [nmvb_pkg::IN_W-1:0]             s_tdata,
  // Output stream; tdata: symbol_code[2:0], lane_number[5:3],
  //   word_number[12:6], match_bits[76:13], zero fill above
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [nmvb_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);
  import nmvb_pkg::*;

  // Configuration registers
  logic              full_word;
  logic [LEN_W-1:0]  read_length;

  // Position state
  logic [POS_W-1:0]  bit_position;
  logic [WNUM_W-1:0] word_counter;
  logic [LEN_W-1:0]  char_position;

  logic [POS_W-1:0]  bit_position_next;
  logic [LEN_W-1:0]  char_position_next;
  logic [POS_W-1:0]  word_limit;
  logic [LEN_W-1:0]  eff_length;
  logic              read_done;
  logic              flush;
  logic              accept;
  word_t             bit_mask;

  drain_load_t       ld;
  drain_status_t     status;
  word_t [DRAIN_N-1:0] load_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_word   <= 1'b0;
      read_length <= READ_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FULL_WORD:   full_word   <= cfg_data[0];
        REG_READ_LENGTH: read_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decide now whether this position closes a word or a read
  assign bit_position_next  = bit_position + POS_W'(1);
  assign char_position_next = char_position + LEN_W'(1);
  assign word_limit = full_word ? POS_W'(WORD_BITS) : POS_W'(WORD_BITS - 1);
  assign eff_length = (read_length == '0) ? LEN_W'(1) : read_length;
  assign read_done  = (char_position_next >= eff_length);
  assign flush      = (bit_position_next >= word_limit) || read_done;
  assign bit_mask   = word_t'(1) << bit_position[5:0];

  // Hold back only a beat that needs the drain stage while it is still busy
  assign s_tready = !flush || status.empty || (status.final_beat && m_tready);
  assign accept   = s_tvalid && s_tready;

  assign ld.load       = accept && flush;
  assign ld.word_index = word_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position  <= '0;
      word_counter  <= '0;
      char_position <= '0;
    end else if (accept) begin
      if (flush) begin
        bit_position <= '0;
        if (read_done) begin
          word_counter  <= '0;
          char_position <= '0;
        end else begin
          word_counter  <= word_counter + WNUM_W'(1);
          char_position <= char_position_next;
        end
      end else begin
        bit_position  <= bit_position_next;
        char_position <= char_position_next;
      end
    end
  end

  // Lane array; lanes past the input width see a zero byte
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    char_t               ch;
    word_t [SYMBOLS-1:0] set_words;

    if (l < IN_LANES) begin : g_in
      assign ch = s_tdata[l*CHAR_W +: CHAR_W];
    end else begin : g_zero
      assign ch = '0;
    end

    nmvb_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ch        (ch),
      .bit_mask  (bit_mask),
      .advance   (accept),
      .flush     (flush),
      .set_words (set_words)
    );

    for (genvar s = 0; s < SYMBOLS; s++) begin : g_sym
      assign load_words[s*LANES + l] = set_words[s];
    end
  end

  nmvb_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .ld         (ld),
    .load_words (load_words),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
